// File: rtl/kdcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad qualifier package
// Payload types, command and result codes and register indexes shared by
// the keypad debounce, combination and auto-repeat block.
// ----------------------------------------------------------------------------
package kdcr_pkg;

   // Key word layout: single keys in the low bits, combination group bits above.
   localparam int RAW_KEYS = 8;
   localparam int COMBOS   = 4;
   localparam int WORD_W   = RAW_KEYS + COMBOS;
   localparam int TIMER_W  = 16;
   localparam int COUNT_W  = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COMBO_PATTERN_0 = 3'd1;
   localparam logic [COUNT_W-1:0]     DEBOUNCE_LIMIT_RESET = 4'd5;

   // Commands carried by a request transaction.
   localparam logic [2:0] CMD_SCAN       = 3'd0;
   localparam logic [2:0] CMD_QUERY      = 3'd1;
   localparam logic [2:0] CMD_MASK_ONCE  = 3'd2;
   localparam logic [2:0] CMD_RECAPTURE  = 3'd3;
   localparam logic [2:0] CMD_READ_EVENT = 3'd4;

   // Scan event codes, also the stored event code.
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_CHANGE   = 2'd1;
   localparam logic [1:0] EV_CONTINUE = 2'd2;

   // Query answers.
   localparam logic [1:0] KEY_NONE   = 2'd0;
   localparam logic [1:0] KEY_DOWN   = 2'd1;
   localparam logic [1:0] KEY_UP     = 2'd2;
   localparam logic [1:0] KEY_REPEAT = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic [RAW_KEYS-1:0] raw_keys;
      logic [WORD_W-1:0]  key_select;
      logic [TIMER_W-1:0] first_delay;
      logic [TIMER_W-1:0] repeat_delay;
      logic               no_repeat;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] scan_event;
      logic [1:0] key_result;
      logic       event_pending;
   } rsp_payload_type;

endpackage
`default_nettype wire

// File: rtl/key_debounce_combo_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad qualifier with debounce, combination keys and auto-repeat
// Debounces eight key pins per scan tick, folds configured pin patterns into
// combination keys, and answers per-key queries with push, release and
// auto-repeat events.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-----------------------------
//   req     | in        | req_valid / req_ready | kdcr_pkg::req_payload_type
//   rsp     | out       | rsp_valid / rsp_ready | kdcr_pkg::rsp_payload_type
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// A request transaction is captured in an input register, evaluated against
// the key state, and its result lands in the output register; one transaction
// is taken every cycle while the response side is not stalled.
// The key state registers update in the same cycle the result is registered.
// A stalled response holds the input register; the request side keeps
// accepting while the input register is empty or moving on.
// Synchronous active-high reset clears the valid flags and the key state and
// returns the debounce limit to five and every combination pattern to zero.
// The configuration port is always ready and takes effect the next cycle.
// ----------------------------------------------------------------------------
module key_debounce_combo_repeat (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  kdcr_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output kdcr_pkg::rsp_payload_type          rsp_payload,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [kdcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [kdcr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import kdcr_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0]  debounce_limit_ff;
   logic [RAW_KEYS-1:0] combo_pattern_ff [COMBOS];

   // Pipeline registers.
   logic            stage_valid_ff;
   req_payload_type stage_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   // Key state.
   logic [WORD_W-1:0]  last_word_ff,   last_word_in;
   logic [WORD_W-1:0]  change_word_ff, change_word_in;
   logic [WORD_W-1:0]  state_word_ff,  state_word_in;
   logic [WORD_W-1:0]  mask_word_ff,   mask_word_in;
   logic [WORD_W-1:0]  repeat_word_ff, repeat_word_in;
   logic [TIMER_W-1:0] first_timer_ff,  first_timer_in;
   logic [TIMER_W-1:0] repeat_timer_ff, repeat_timer_in;
   logic [COUNT_W-1:0] change_count_ff, change_count_in;
   logic [COUNT_W-1:0] hold_count_ff,   hold_count_in;
   logic [1:0]         event_code_ff,   event_code_in;

   logic req_fire;
   logic fire;

   // Scan word after combination matching.
   logic [WORD_W-1:0] scan_word;
   logic [WORD_W-1:0] combo_mask;
   logic              combo_found;

   assign csr_ready   = 1'b1;
   assign fire        = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !stage_valid_ff || fire;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration writes. Indexes past the last pattern are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_limit_ff <= DEBOUNCE_LIMIT_RESET;
         for (int k = 0; k < COMBOS; k++) begin
            combo_pattern_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_DEBOUNCE_LIMIT) begin
            debounce_limit_ff <= csr_data[COUNT_W-1:0];
         end
         for (int k = 0; k < COMBOS; k++) begin
            if (csr_index == REG_COMBO_PATTERN_0 + CSR_INDEX_W'(k)) begin
               combo_pattern_ff[k] <= csr_data[RAW_KEYS-1:0];
            end
         end
      end
   end

   // Input register and output register with their valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            stage_valid_ff <= 1'b1;
         end else if (fire) begin
            stage_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Combination matching. Once a pattern matches, the found flag keeps the
   // later patterns from matching, so the lowest matching pattern wins and
   // the word holds only that group bit.
   always_comb begin
      scan_word   = {{COMBOS{1'b0}}, stage_ff.raw_keys};
      combo_mask  = '0;
      combo_found = 1'b0;
      for (int k = 0; k < COMBOS; k++) begin
         if (!combo_found && combo_pattern_ff[k] != '0 &&
             stage_ff.raw_keys == combo_pattern_ff[k]) begin
            combo_found             = 1'b1;
            scan_word               = '0;
            scan_word[RAW_KEYS + k] = 1'b1;
            combo_mask              = {{COMBOS{1'b0}}, combo_pattern_ff[k]};
         end
      end
   end

   // Per-command state update and result.
   always_comb begin
      logic [COUNT_W:0]  change_next;
      logic [COUNT_W:0]  hold_next;
      logic [COUNT_W:0]  limit_ext;
      logic [WORD_W-1:0] sel;
      logic [1:0]        ev;

      change_next = {1'b0, change_count_ff} + (COUNT_W+1)'(1);
      hold_next   = {1'b0, hold_count_ff} + (COUNT_W+1)'(1);
      limit_ext   = {1'b0, debounce_limit_ff};
      sel         = stage_ff.key_select;
      ev          = EV_NONE;

      last_word_in    = last_word_ff;
      change_word_in  = change_word_ff;
      state_word_in   = state_word_ff;
      mask_word_in    = mask_word_ff;
      repeat_word_in  = repeat_word_ff;
      first_timer_in  = first_timer_ff;
      repeat_timer_in = repeat_timer_ff;
      change_count_in = change_count_ff;
      hold_count_in   = hold_count_ff;
      event_code_in   = event_code_ff;
      rsp_in          = '0;

      if (fire) begin
         case (stage_ff.command)
            CMD_SCAN: begin
               if (first_timer_ff != '0) begin
                  first_timer_in = first_timer_ff - TIMER_W'(1);
               end
               if (repeat_timer_ff != '0) begin
                  repeat_timer_in = repeat_timer_ff - TIMER_W'(1);
               end
               mask_word_in = mask_word_ff | combo_mask;
               if (scan_word != last_word_ff) begin
                  hold_count_in = '0;
                  if (change_next > limit_ext) begin
                     change_count_in = '0;
                     change_word_in  = scan_word ^ last_word_ff;
                     last_word_in    = scan_word;
                     state_word_in   = scan_word;
                     ev              = EV_CHANGE;
                  end else begin
                     change_count_in = change_next[COUNT_W-1:0];
                  end
               end else begin
                  change_count_in = '0;
                  if (scan_word != '0) begin
                     if (hold_next > limit_ext) begin
                        hold_count_in = '0;
                        state_word_in = scan_word;
                        ev            = EV_CONTINUE;
                     end else begin
                        hold_count_in = hold_next[COUNT_W-1:0];
                     end
                  end else begin
                     // All keys released: drop masks and repeat tracking.
                     hold_count_in  = '0;
                     state_word_in  = '0;
                     mask_word_in   = '0;
                     repeat_word_in = '0;
                  end
               end
               event_code_in     = ev;
               rsp_in.scan_event = ev;
            end
            CMD_QUERY: begin
               if ((mask_word_ff & sel) != '0) begin
                  rsp_in.key_result = KEY_NONE;
               end else if ((repeat_word_ff & sel) != '0) begin
                  if ((change_word_ff & sel) != '0) begin
                     change_word_in = '0;
                     if ((state_word_ff & sel) == '0) begin
                        rsp_in.key_result = KEY_UP;
                     end
                  end
                  if ((state_word_ff & sel) != '0 && first_timer_ff == '0 &&
                      repeat_timer_ff == '0) begin
                     repeat_timer_in   = stage_ff.repeat_delay;
                     rsp_in.key_result = KEY_REPEAT;
                  end
               end else if ((change_word_ff & sel) != '0) begin
                  change_word_in = '0;
                  if ((state_word_ff & sel) != '0) begin
                     if (stage_ff.no_repeat) begin
                        first_timer_in  = '0;
                        repeat_timer_in = '0;
                     end else begin
                        repeat_word_in  = repeat_word_ff | sel;
                        first_timer_in  = stage_ff.first_delay;
                        repeat_timer_in = '0;
                     end
                     rsp_in.key_result = KEY_DOWN;
                  end else begin
                     rsp_in.key_result = KEY_UP;
                  end
               end
            end
            CMD_MASK_ONCE: begin
               mask_word_in = mask_word_ff | sel;
            end
            CMD_RECAPTURE: begin
               last_word_in   = last_word_ff & ~sel;
               repeat_word_in = repeat_word_ff & ~sel;
            end
            CMD_READ_EVENT: begin
               if (event_code_ff != EV_NONE) begin
                  event_code_in        = EV_NONE;
                  rsp_in.event_pending = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_word_ff    <= '0;
         change_word_ff  <= '0;
         state_word_ff   <= '0;
         mask_word_ff    <= '0;
         repeat_word_ff  <= '0;
         first_timer_ff  <= '0;
         repeat_timer_ff <= '0;
         change_count_ff <= '0;
         hold_count_ff   <= '0;
         event_code_ff   <= EV_NONE;
      end else begin
         last_word_ff    <= last_word_in;
         change_word_ff  <= change_word_in;
         state_word_ff   <= state_word_in;
         mask_word_ff    <= mask_word_in;
         repeat_word_ff  <= repeat_word_in;
         first_timer_ff  <= first_timer_in;
         repeat_timer_ff <= repeat_timer_in;
         change_count_ff <= change_count_in;
         hold_count_ff   <= hold_count_in;
         event_code_ff   <= event_code_in;
      end
   end

   // A key word is either settling toward a change or being held, never both.
   assert property (@(posedge clock) disable iff (reset)
      !(change_count_ff != '0 && hold_count_ff != '0))
      else $error("change and hold counts both running");

   // A response carries at most one kind of answer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_ff.scan_event != EV_NONE,
                                   rsp_ff.key_result != KEY_NONE,
                                   rsp_ff.event_pending}) <= 1)
      else $error("response carries more than one answer");

   // A scan that reports an event leaves it pending for a later read.
   assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_in.scan_event != EV_NONE) |=> event_code_ff != EV_NONE)
      else $error("reported scan event not recorded");

   // A transaction in the input register is not dropped while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !fire) |=> stage_valid_ff)
      else $error("stalled transaction lost from input register");

endmodule
`default_nettype wire

// File: test/tb_key_debounce_combo_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad qualifier testbench
// Drives scan, query, mask, recapture and event-read transactions into the
// keypad debounce block, keeps its own model of the key words, counters and
// delay timers, and checks every response field against that model while
// both channels idle at random and the response side holds off for long
// stretches.
// ----------------------------------------------------------------------------
module tb_key_debounce_combo_repeat;
   import kdcr_pkg::*;

   // Command codes the block defines no meaning for; they must change nothing.
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   // HOLD_OFF_CYCLES sets the length of a hold-off of the response side; the watchdog
   // allows far more quiet cycles than that before it calls the run hung.
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int REPORT_LIMIT    = 10;
   localparam int COMBO_IDX_W     = $clog2(COMBOS);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   req_payload_type              req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   rsp_payload_type              rsp_payload;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index   = '0;
   logic [CSR_DATA_W-1:0]        csr_data    = '0;

   // Settings of the block as the testbench believes them to be.
   logic [COUNT_W-1:0]           debounce_limit = DEBOUNCE_LIMIT_RESET;
   logic [RAW_KEYS-1:0]          combo_pattern [COMBOS] = '{default: '0};

   // Key state mirrored from the block; everything starts cleared.
   logic [WORD_W-1:0]            last_word    = '0;
   logic [WORD_W-1:0]            change_word  = '0;
   logic [WORD_W-1:0]            state_word   = '0;
   logic [WORD_W-1:0]            mask_word    = '0;
   logic [WORD_W-1:0]            repeat_word  = '0;
   logic [TIMER_W-1:0]           first_timer  = '0;
   logic [TIMER_W-1:0]           repeat_timer = '0;
   logic [COUNT_W-1:0]           change_count = '0;
   logic [COUNT_W-1:0]           hold_count   = '0;
   logic [1:0]                   event_code   = EV_NONE;

   req_payload_type              key_items [$];
   rsp_payload_type              awaited_answers [$];

   logic req_taken    = 1'b0;
   int   idle_pct     = 35;
   int   items_in     = 0;
   int   failures     = 0;
   int   quiet_cycles = 0;
   int   hold_left    = 0;
   int   holds_done   = 0;

   key_debounce_combo_repeat dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one request transaction to the mirrored key state and returns
   // the response the block owes for it. Exactly one response per request.
   function automatic rsp_payload_type keypad_answer(input req_payload_type item);
      rsp_payload_type     answer;
      logic [WORD_W-1:0]   sel;
      logic [WORD_W-1:0]   word;
      logic                folded;
      int unsigned         next_count;
      int                  k;
      answer = '0;
      sel    = item.key_select;
      case (item.command)
         CMD_SCAN: begin
            if (first_timer != '0) first_timer = first_timer - 1'b1;
            if (repeat_timer != '0) repeat_timer = repeat_timer - 1'b1;
            // Only the first matching pattern folds the pins into a group
            // bit; once folded, the folded flag keeps any later pattern from matching.
            word   = WORD_W'(item.raw_keys);
            folded = 1'b0;
            for (k = 0; k < COMBOS; k++) begin
               if (!folded && combo_pattern[k] != '0 && item.raw_keys == combo_pattern[k]) begin
                  folded                  = 1'b1;
                  word[RAW_KEYS + k]      = 1'b1;
                  word[RAW_KEYS-1:0]     &= ~combo_pattern[k];
                  mask_word[RAW_KEYS-1:0] |= combo_pattern[k];
               end
            end
            event_code = EV_NONE;
            if (word != last_word) begin
               hold_count = '0;
               next_count = change_count + 1;
               if (next_count > debounce_limit) begin
                  change_count = '0;
                  change_word  = word ^ last_word;
                  last_word    = word;
                  state_word   = word;
                  event_code   = EV_CHANGE;
               end else begin
                  change_count = COUNT_W'(next_count);
               end
            end else begin
               change_count = '0;
               if (word != '0) begin
                  next_count = hold_count + 1;
                  if (next_count > debounce_limit) begin
                     hold_count = '0;
                     state_word = word;
                     event_code = EV_CONTINUE;
                  end else begin
                     hold_count = COUNT_W'(next_count);
                  end
               end else begin
                  // All keys released and settled: forget masks and repeats.
                  hold_count  = '0;
                  state_word  = '0;
                  mask_word   = '0;
                  repeat_word = '0;
               end
            end
            answer.scan_event = event_code;
         end
         CMD_QUERY: begin
            if ((mask_word & sel) != '0) begin
               answer.key_result = KEY_NONE;
            end else if ((repeat_word & sel) != '0) begin
               // A key already repeating: a pending change either releases
               // it or is simply swallowed, then the repeat timer is checked.
               if ((change_word & sel) != '0) begin
                  change_word = '0;
                  if ((state_word & sel) == '0) answer.key_result = KEY_UP;
               end
               if ((state_word & sel) != '0 && first_timer == '0 && repeat_timer == '0) begin
                  repeat_timer      = item.repeat_delay;
                  answer.key_result = KEY_REPEAT;
               end
            end else if ((change_word & sel) != '0) begin
               change_word = '0;
               if ((state_word & sel) != '0) begin
                  if (item.no_repeat) begin
                     first_timer = '0;
                  end else begin
                     repeat_word |= sel;
                     first_timer  = item.first_delay;
                  end
                  repeat_timer      = '0;
                  answer.key_result = KEY_DOWN;
               end else begin
                  answer.key_result = KEY_UP;
               end
            end
         end
         CMD_MASK_ONCE: begin
            mask_word |= sel;
         end
         CMD_RECAPTURE: begin
            last_word   &= ~sel;
            repeat_word &= ~sel;
         end
         CMD_READ_EVENT: begin
            if (event_code != EV_NONE) begin
               event_code           = EV_NONE;
               answer.event_pending = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   function automatic req_payload_type item_of(input logic [2:0] cmd,
                                               input logic [RAW_KEYS-1:0] raw,
                                               input logic [WORD_W-1:0] sel,
                                               input logic [TIMER_W-1:0] first,
                                               input logic [TIMER_W-1:0] again,
                                               input logic once);
      req_payload_type item;
      item.command      = cmd;
      item.raw_keys     = raw;
      item.key_select   = sel;
      item.first_delay  = first;
      item.repeat_delay = again;
      item.no_repeat    = once;
      return item;
   endfunction

   // Random content in every field; the caller picks the command and then
   // overrides whatever fields it wants to steer.
   function automatic req_payload_type random_item(input logic [2:0] cmd);
      return item_of(cmd, RAW_KEYS'($urandom), WORD_W'($urandom), TIMER_W'($urandom),
                     TIMER_W'($urandom), 1'($urandom));
   endfunction

   // Most of the random traffic is a key level held for long enough to pass
   // the debounce limit, with queries aimed at the key word bits that level
   // produces, so that presses, releases, holds and repeats all happen. The
   // rest is bounces and fully random transactions of any command.
   task automatic queue_random(input int count);
      int                  stop;
      int                  pick;
      int                  ticks;
      int                  i;
      int                  k;
      logic [RAW_KEYS-1:0] raw;
      logic [WORD_W-1:0]   aim;
      logic [WORD_W-1:0]   prev_aim;
      req_payload_type     item;
      stop     = key_items.size() + count;
      prev_aim = WORD_W'(1);
      while (key_items.size() < stop) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            if (pick < 30)      raw = '0;
            else if (pick < 60) raw = combo_pattern[COMBO_IDX_W'($urandom_range(COMBOS - 1))];
            else if (pick < 85) raw = RAW_KEYS'(1) << $urandom_range(RAW_KEYS - 1);
            else                raw = RAW_KEYS'($urandom);
            // Aim at the group bit when the level folds into a combination,
            // at the pins otherwise, and at the last target on a release.
            aim = WORD_W'(raw);
            for (k = COMBOS - 1; k >= 0; k--) begin
               if (combo_pattern[k] != '0 && raw == combo_pattern[k]) begin
                  aim = WORD_W'(1) << (RAW_KEYS + k);
               end
            end
            if (raw == '0) aim = prev_aim;
            prev_aim = aim;
            if ($urandom_range(4) == 0) ticks = $urandom_range(debounce_limit);
            else                        ticks = debounce_limit + 1 + $urandom_range(3);
            for (i = 0; i < ticks; i++) begin
               item          = random_item(CMD_SCAN);
               item.raw_keys = raw;
               key_items.push_back(item);
               if ($urandom_range(2) == 0) begin
                  item = random_item(CMD_QUERY);
                  if ($urandom_range(4) != 0) item.key_select = aim;
                  if ($urandom_range(4) != 0) begin
                     item.first_delay  = TIMER_W'($urandom_range(7));
                     item.repeat_delay = TIMER_W'($urandom_range(7));
                  end
                  item.no_repeat = ($urandom_range(4) == 0);
                  key_items.push_back(item);
               end
               if ($urandom_range(7) == 0) key_items.push_back(random_item(CMD_READ_EVENT));
            end
         end else begin
            key_items.push_back(random_item(3'($urandom_range(7))));
         end
      end
   endtask

   // One write on the register port; the model takes the new value at the
   // same edge the block does.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_DEBOUNCE_LIMIT) begin
         debounce_limit = data[COUNT_W-1:0];
      end else begin
         combo_pattern[COMBO_IDX_W'(index - REG_COMBO_PATTERN_0)] = data[RAW_KEYS-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The limit goes out with random upper bits, which the block must ignore.
   task automatic set_config(input logic [COUNT_W-1:0] limit,
                             input logic [COMBOS-1:0][RAW_KEYS-1:0] patterns);
      int k;
      write_reg(REG_DEBOUNCE_LIMIT, CSR_DATA_W'({4'($urandom), limit}));
      for (k = 0; k < COMBOS; k++) begin
         write_reg(REG_COMBO_PATTERN_0 + CSR_INDEX_W'(k), patterns[k]);
      end
   endtask

   // Waits until every queued transaction has gone in and every response has
   // come back, then lets the pipeline settle a little longer.
   task automatic drain();
      while (key_items.size() != 0 || req_valid || awaited_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Request driver: a new transaction goes out only once the previous one
   // was taken, and then only if the random idle roll allows it.
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (key_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= key_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls, plus two long hold-offs started from the
   // transaction count so that they land while requests keep coming and the
   // block has to back up into its request port. Both fall outside the
   // stretch that runs with no idling.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left  = hold_left - 1;
      end else if (holds_done < 2 && items_in >= 150 + 700 * holds_done) begin
         rsp_ready  <= 1'b0;
         hold_left   = HOLD_OFF_CYCLES;
         holds_done  = holds_done + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Everything is sampled at the rising edge, where the inputs have been
   // steady since the falling edge and the outputs still hold their values
   // from before the edge.
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      logic            req_fire;
      logic            rsp_fire;
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      req_taken <= req_fire;
      if (req_fire) begin
         awaited_answers.push_back(keypad_answer(req_payload));
         items_in = items_in + 1;
      end
      if (rsp_fire) begin
         if (awaited_answers.size() == 0) begin
            failures = failures + 1;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected response at %0t:", $time,
                        " scan_event %0d", rsp_payload.scan_event,
                        " key_result %0d", rsp_payload.key_result,
                        " event_pending %0d", rsp_payload.event_pending);
            end
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_payload.scan_event !== want.scan_event ||
                rsp_payload.key_result !== want.key_result ||
                rsp_payload.event_pending !== want.event_pending) begin
               failures = failures + 1;
               if (failures <= REPORT_LIMIT) begin
                  $display("mismatch at %0t:", $time,
                           " scan_event %0d/%0d", want.scan_event,
                           rsp_payload.scan_event,
                           " key_result %0d/%0d", want.key_result,
                           rsp_payload.key_result,
                           " event_pending %0d/%0d", want.event_pending,
                           rsp_payload.event_pending,
                           " (expected/actual)");
               end
            end
         end
      end
      // Watchdog: any transaction on any channel counts as progress.
      if (req_fire || rsp_fire || (csr_valid && csr_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with an immediate debounce limit. Patterns 0 and 1 are
      // the same, so only combination 0 may ever fold those pins; pattern 2
      // covers all pins and pattern 3 the top pin.
      set_config(4'd0, {8'h80, 8'hFF, 8'h03, 8'h03});
      idle_pct = 35;
      key_items.push_back(item_of(CMD_SCAN,       8'h03, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h100, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h100, 16'h0000, 16'hFFFF, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h100, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'h03, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_READ_EVENT, 8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_READ_EVENT, 8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'hFF, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h100, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_MASK_ONCE,  8'h00, 12'hFFF, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h001, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'h80, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_RECAPTURE,  8'h00, 12'hFFF, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h800, 16'hFFFF, 16'hFFFF, 1'b1));
      // Unused command codes with every field at its top value.
      key_items.push_back(item_of(CMD_SPARE_5,    8'hFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      key_items.push_back(item_of(CMD_SPARE_6,    8'hFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      key_items.push_back(item_of(CMD_SPARE_7,    8'hFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      // A single key pressed with the longest first delay, then released.
      key_items.push_back(item_of(CMD_SCAN,       8'h01, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h001, 16'hFFFF, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h001, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_SCAN,       8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h001, 16'h0000, 16'h0000, 1'b0));
      key_items.push_back(item_of(CMD_QUERY,      8'h00, 12'h000, 16'h0000, 16'h0000, 1'b0));
      drain();

      // Longest debounce: sixteen equal ticks are needed for any event.
      set_config(4'd15, (COMBOS * RAW_KEYS)'($urandom));
      queue_random(245);
      drain();

      // Immediate debounce with no random idling on either side.
      set_config(4'd0, (COMBOS * RAW_KEYS)'($urandom));
      idle_pct = 0;
      queue_random(245);
      drain();

      // Disabled patterns next to the all-pins and single-pin patterns.
      set_config(4'd2, {8'h00, 8'h01, 8'hFF, 8'h00});
      idle_pct = 35;
      queue_random(245);
      drain();

      set_config(COUNT_W'($urandom), (COMBOS * RAW_KEYS)'($urandom));
      queue_random(245);
      drain();

      set_config(DEBOUNCE_LIMIT_RESET, (COMBOS * RAW_KEYS)'($urandom));
      queue_random(245);
      drain();

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
rtl/kdcr_pkg.sv
rtl/key_debounce_combo_repeat.sv
test/tb_key_debounce_combo_repeat.sv
